// File: hw/rtl/htts_pkg.sv
// Package for the TTL key/value table: constants, field types, helpers.
// No dependencies.
`timescale 1ns / 1ps
package htts_pkg;
   localparam int CAPACITY = 256;

   localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
   localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;

   localparam logic [1:0] MODE_GET = 2'd0;
   localparam logic [1:0] MODE_SET = 2'd1;
   localparam logic [1:0] MODE_DEL = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_MISS   = 2'd1;
   localparam logic [1:0] ST_BADLEN = 2'd2;
   localparam logic [1:0] ST_NOROOM = 2'd3;

   localparam logic [0:0] CSR_KEY_LIMIT   = 1'd0;
   localparam logic [0:0] CSR_VALUE_LIMIT = 1'd1;

   typedef struct packed {
      logic [3:0]  read_limit;
      logic [31:0] now_ms;
      logic [31:0] ttl_ms;
      logic [3:0]  value_length;
      logic [63:0] value_bytes;
      logic [3:0]  key_length;
      logic [63:0] key_bytes;
      logic [1:0]  mode;
   } req_type;

   function automatic logic [63:0] byte_mask(input logic [3:0] n);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < n) m[8*i +: 8] = 8'hFF;
      end
      return m;
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hFFFFFFFF) ? v : v + 32'd1;
   endfunction
endpackage

// File: hw/rtl/htts_hash.sv
// Iterative FNV-1a hash over up to eight key bytes, one byte per cycle.
// Depends on htts_pkg.
`timescale 1ns / 1ps
module htts_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] key,
   input  logic [3:0]  len,
   output logic        done,
   output logic [63:0] hash
);
   logic [63:0] h_ff, h_in;
   logic [3:0]  i_ff, i_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] x;
   logic [63:0] xp;

   assign x = h_ff ^ {56'd0, key[{i_ff[2:0], 3'b000} +: 8]};
   // x times the FNV prime (2^40 + 0x1B3) as shifts and adds
   assign xp = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;

   always_comb begin
      h_in = h_ff;
      i_in = i_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         h_in = htts_pkg::FNV_BASIS;
         i_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (i_ff == len) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            h_in = xp;
            i_in = i_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      i_ff <= i_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign hash = h_ff;
endmodule

// File: hw/rtl/hash_table_ttl_store_top.sv
// Top level of the TTL key/value table with linear probing.
// Flow: a bad length is answered without hashing; else the key is hashed, then each probed
// slot is read and checked; a removal frees the hole and moves later entries back, then the response.
// Requests: one at a time; the next is accepted in the cycle after the response transaction.
// Reset: synchronous; a clearing pass writes every slot empty
// before the first request is accepted.
// Depends on htts_pkg, htts_hash.
`timescale 1ns / 1ps
module hash_table_ttl_store_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [3:0]   csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode, key_bytes, key_length, value_bytes, value_length, ttl_ms, now_ms,
   // read_limit, pad
   input  logic [207:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, read_value, read_length, live_entries, hit_total, miss_total,
   // eviction_total, pad
   output logic [175:0] rsp_tdata
);
   localparam int CAPACITY = htts_pkg::CAPACITY;
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int HALF = CAPACITY / 2;

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_HASH  = 4'd2;
   localparam logic [3:0] S_PRD   = 4'd3;
   localparam logic [3:0] S_PCHK  = 4'd4;
   localparam logic [3:0] S_RRD   = 4'd5;
   localparam logic [3:0] S_RCHK  = 4'd6;
   localparam logic [3:0] S_RCLR  = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   typedef struct packed {
      logic [3:0]    ulen;
      logic [63:0]   key;
      logic [AW-1:0] home;
      logic [63:0]   val;
      logic [3:0]    vlen;
      logic [31:0]   exp;
   } ent_type;

   ent_type mem [CAPACITY];
   ent_type rd_ff;
   logic           we;
   logic [AW-1:0]  waddr, raddr;
   ent_type        wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   htts_pkg::req_type r_ff, r_in;
   logic [3:0]    st_ff, st_in;
   logic [3:0]    klim_ff, vlim_ff;
   logic [AW-1:0] idx_ff, idx_in, hole_ff, hole_in, home_ff, home_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] steps_ff, steps_in;
   logic [7:0]    occ_ff, occ_in;
   logic [31:0]   hit_ff, hit_in, miss_ff, miss_in, ev_ff, ev_in;
   logic [1:0]    stat_ff, stat_in;
   logic [63:0]   rv_ff, rv_in;
   logic [3:0]    rl_ff, rl_in;
   logic          hstart, hdone;
   logic [63:0]   hval;
   logic [63:0]   kmask, vmask;
   logic [AW-1:0] nidx;
   logic [3:0]    rlim, rl;
   logic [31:0]   expv;
   logic          bad, match, expired, fill;
   logic          req_acc;

   htts_hash u_hash (
      .clock(clock), .reset(reset), .start(hstart),
      .key(r_ff.key_bytes & kmask), .len(r_ff.key_length),
      .done(hdone), .hash(hval)
   );

   assign kmask = htts_pkg::byte_mask(r_ff.key_length);
   assign vmask = htts_pkg::byte_mask(r_ff.value_length);
   assign req_tready = (st_ff == S_IDLE);
   assign req_acc = req_tvalid && req_tready;
   assign nidx = (32'(idx_ff) + 32'd1 >= 32'(CAPACITY)) ? '0 : AW'(32'(idx_ff) + 32'd1);
   assign rlim = (r_ff.read_limit > 4'd8) ? 4'd8 : r_ff.read_limit;
   assign rl = (rd_ff.vlen > rlim) ? rlim : rd_ff.vlen;
   assign expv = (r_ff.ttl_ms != 32'd0) ? r_ff.now_ms + r_ff.ttl_ms : 32'd0;
   assign match = (rd_ff.ulen == r_ff.key_length) && (rd_ff.key == (r_ff.key_bytes & kmask));
   assign expired = (rd_ff.exp != 32'd0) && (rd_ff.exp <= r_ff.now_ms);
   assign fill = (hole_ff <= idx_ff) ?
                 !(rd_ff.home > hole_ff && rd_ff.home <= idx_ff) :
                 !(rd_ff.home > hole_ff || rd_ff.home <= idx_ff);

   always_comb begin
      bad = (r_ff.mode == 2'd3) || (r_ff.key_length == 4'd0) ||
            (r_ff.key_length > klim_ff) || (r_ff.key_length > 4'd8);
      if (r_ff.mode == htts_pkg::MODE_SET &&
          (r_ff.value_length > vlim_ff || r_ff.value_length > 4'd8)) bad = 1'b1;
   end

   always_comb begin
      st_in = st_ff; r_in = r_ff; idx_in = idx_ff; hole_in = hole_ff;
      home_in = home_ff; cnt_in = cnt_ff; steps_in = steps_ff; occ_in = occ_ff;
      hit_in = hit_ff; miss_in = miss_ff; ev_in = ev_ff; stat_in = stat_ff;
      rv_in = rv_ff; rl_in = rl_ff;
      hstart = 1'b0; we = 1'b0; waddr = idx_ff; raddr = idx_ff; wdata = rd_ff;
      case (st_ff)
         S_CLR: begin
            we = 1'b1; waddr = cnt_ff[AW-1:0]; wdata = '0;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(CAPACITY - 1)) st_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_acc) begin
               r_in = htts_pkg::req_type'(req_tdata[205:0]);
               st_in = S_HASH;
               hstart = 1'b1;
            end
         end
         S_HASH: begin
            rv_in = '0; rl_in = '0;
            if (bad) begin
               stat_in = htts_pkg::ST_BADLEN; st_in = S_OUT;
            end else if (hdone) begin
               // home slot: low bits of the hash
               idx_in = hval[AW-1:0];
               home_in = hval[AW-1:0];
               steps_in = '0;
               stat_in = (r_ff.mode == htts_pkg::MODE_SET) ?
                         htts_pkg::ST_NOROOM : htts_pkg::ST_MISS;
               st_in = S_PRD;
            end
         end
         S_PRD: begin
            raddr = idx_ff; st_in = S_PCHK;
         end
         S_PCHK: begin
            st_in = S_OUT;
            if (rd_ff.ulen == 4'd0) begin
               if (r_ff.mode == htts_pkg::MODE_SET && 32'(occ_ff) < 32'(HALF)) begin
                  we = 1'b1;
                  wdata.ulen = r_ff.key_length;
                  wdata.key = r_ff.key_bytes & kmask;
                  wdata.home = home_ff;
                  wdata.val = r_ff.value_bytes & vmask;
                  wdata.vlen = r_ff.value_length;
                  wdata.exp = expv;
                  occ_in = occ_ff + 8'd1;
                  stat_in = htts_pkg::ST_OK;
               end
            end else if (match) begin
               if (r_ff.mode == htts_pkg::MODE_GET) begin
                  if (expired) begin
                     hole_in = idx_ff; steps_in = '0; st_in = S_RCLR;
                     if (occ_ff != 8'd0) occ_in = occ_ff - 8'd1;
                     ev_in = htts_pkg::sat_inc(ev_ff);
                  end else begin
                     rl_in = rl;
                     rv_in = rd_ff.val & htts_pkg::byte_mask(rl);
                     stat_in = htts_pkg::ST_OK;
                  end
               end else if (r_ff.mode == htts_pkg::MODE_SET) begin
                  we = 1'b1;
                  wdata.val = r_ff.value_bytes & vmask;
                  wdata.vlen = r_ff.value_length;
                  wdata.exp = expv;
                  stat_in = htts_pkg::ST_OK;
               end else begin
                  hole_in = idx_ff; steps_in = '0; st_in = S_RCLR;
                  if (occ_ff != 8'd0) occ_in = occ_ff - 8'd1;
                  stat_in = htts_pkg::ST_OK;
               end
            end else begin
               idx_in = nidx;
               steps_in = steps_ff + CW'(1);
               if (32'(steps_ff) + 32'd1 < 32'(HALF)) st_in = S_PRD;
            end
            if (st_in == S_OUT && r_ff.mode == htts_pkg::MODE_GET) begin
               if (stat_in == htts_pkg::ST_OK) hit_in = htts_pkg::sat_inc(hit_ff);
               else miss_in = htts_pkg::sat_inc(miss_ff);
            end
         end
         S_RCLR: begin
            // free the hole, then look at the next slot
            we = 1'b1; waddr = hole_ff; wdata = '0;
            idx_in = nidx; steps_in = steps_ff + CW'(1);
            st_in = (32'(steps_ff) + 32'd1 > 32'(CAPACITY)) ? S_OUT : S_RRD;
         end
         S_RRD: begin
            raddr = idx_ff; st_in = S_RCHK;
         end
         S_RCHK: begin
            if (rd_ff.ulen == 4'd0) begin
               st_in = S_OUT;
            end else if (fill) begin
               we = 1'b1; waddr = hole_ff; wdata = rd_ff;
               hole_in = idx_ff; st_in = S_RCLR;
            end else begin
               idx_in = nidx; steps_in = steps_ff + CW'(1);
               st_in = (32'(steps_ff) + 32'd1 > 32'(CAPACITY)) ? S_OUT : S_RRD;
            end
            if (st_in == S_OUT && r_ff.mode == htts_pkg::MODE_GET)
               miss_in = htts_pkg::sat_inc(miss_ff);
         end
         S_OUT: begin
            if (rsp_tready) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in; idx_ff <= idx_in; hole_ff <= hole_in; home_ff <= home_in;
      steps_ff <= steps_in; stat_ff <= stat_in; rv_ff <= rv_in; rl_ff <= rl_in;
      if (reset) begin
         st_ff <= S_CLR; cnt_ff <= '0; occ_ff <= '0;
         hit_ff <= '0; miss_ff <= '0; ev_ff <= '0;
         klim_ff <= 4'd8; vlim_ff <= 4'd8;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; occ_ff <= occ_in;
         hit_ff <= hit_in; miss_ff <= miss_in; ev_ff <= ev_in;
         if (csr_we && csr_index == htts_pkg::CSR_KEY_LIMIT) klim_ff <= csr_wdata;
         if (csr_we && csr_index == htts_pkg::CSR_VALUE_LIMIT) vlim_ff <= csr_wdata;
      end
   end

   assign rsp_tvalid = (st_ff == S_OUT);
   assign rsp_tdata = {2'd0, ev_ff, miss_ff, hit_ff, occ_ff, rl_ff, rv_ff, stat_ff};
endmodule
